### hw/rtl/hsvl_pkg.sv
// Shared types, command codes and arithmetic helpers of the HSV light controller.
// Used by the front, the queue, the back end and the top level.
package hsvl_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_ON_OFF     = 3'd0;
  localparam logic [2:0] CMD_LEVEL      = 3'd1;
  localparam logic [2:0] CMD_HUE        = 3'd2;
  localparam logic [2:0] CMD_SATURATION = 3'd3;

  localparam logic [8:0] DEG_FULL   = 9'd360;
  localparam int unsigned HUE_SPAN   = 254;
  localparam int unsigned DEG_REGION = 60;
  localparam logic [7:0] COMP_MAX   = 8'd255;
  localparam logic [7:0] LEVEL_RESET = 8'd254;

  // One snapshot of the light state, handed from the front to the back end.
  // The hue is already split into its region and scaled remainder.
  typedef struct packed {
    logic       on;
    logic [7:0] level;
    logic [7:0] sat;
    logic [2:0] region;
    logic [7:0] rem;
  } hsvl_item_t;

  typedef logic [10:0] hue_tab_t [256];

  // Built at elaboration: {region, remainder scaled to 0..250} for each hue code.
  function automatic hue_tab_t build_hue_tab();
    hue_tab_t    tab;
    int unsigned h;
    for (int unsigned i = 0; i < 256; i++) begin
      h = (i * DEG_FULL) / HUE_SPAN;
      if (h >= DEG_FULL) begin
        h = h - DEG_FULL;
      end
      tab[i] = {3'(h / DEG_REGION), 8'(((h % DEG_REGION) * COMP_MAX) / DEG_REGION)};
    end
    return tab;
  endfunction

  localparam hue_tab_t HUE_TAB = build_hue_tab();

  // Exact x / 255 for any product of two 8-bit values.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

### hw/rtl/hsv_light_attribute_controller_core.sv
// HSV light attribute controller, top level.
//
// Input channel (in_valid/in_ready): one attribute-write transaction carrying
// in_command, in_value and in_status_ok. On/off, level, hue and saturation
// writes update the stored attributes; any other command only refreshes.
// A transaction with in_status_ok low is taken and dropped without effect.
// Output channel (out_valid/out_ready): one color transaction per successful
// write, with out_red, out_green, out_blue and out_lit, in arrival order.
//
// The front updates the attributes in the accept cycle and queues a snapshot
// (QueueDepth entries). The back end works one snapshot at a time: a lit,
// saturated color passes from queue to output register through a pop step,
// six steps of the shared 8x8 multiplier and a select step; an off or gray
// color goes from the pop straight to the select. The back end takes no new
// snapshot until the current color is in the output register. With the back
// end idle, out_valid rises after these steps; queued snapshots add their wait.
// When the receiver stalls, the result waits in the output register, the back
// end finishes the next color and then holds, and the front keeps accepting
// until the queue is full. Reset (rst_n low, synchronous) empties the queue
// and output and restores off, level 254, hue 0, saturation 0.
module hsv_light_attribute_controller_core #(
  parameter int unsigned QueueDepth = hsvl_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [7:0] in_value,
  input  logic       in_status_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_lit
);
  import hsvl_pkg::*;

  logic       push_valid, push_ready;
  hsvl_item_t push_item;
  logic       pop_valid, pop_ready;
  hsvl_item_t pop_item;

  hsvl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_value     (in_value),
    .in_status_ok (in_status_ok),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  hsvl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hsvl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_lit   (out_lit)
  );

endmodule

### hw/rtl/hsvl_front.sv
// Front end: accepts attribute-write transactions, keeps the light attributes
// and pushes one state snapshot per successful write. Depends on hsvl_pkg.
module hsvl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_command,
  input  logic [7:0]          in_value,
  input  logic                in_status_ok,
  output logic                push_valid,
  input  logic                push_ready,
  output hsvl_pkg::hsvl_item_t push_item
);
  import hsvl_pkg::*;

  logic       on_r, on_nxt;
  logic [7:0] level_r, level_nxt;
  logic [7:0] hue_r, hue_nxt;
  logic [7:0] sat_r, sat_nxt;
  logic       take;
  logic [10:0] hue_entry;

  // A failed write is still taken off the channel, it just leaves no trace.
  assign in_ready = push_ready;
  assign take     = in_valid && push_ready && in_status_ok;

  always_comb begin
    on_nxt    = on_r;
    level_nxt = level_r;
    hue_nxt   = hue_r;
    sat_nxt   = sat_r;
    if (take) begin
      case (in_command)
        CMD_ON_OFF:     on_nxt    = (in_value != 8'd0);
        CMD_LEVEL:      level_nxt = in_value;
        CMD_HUE:        hue_nxt   = in_value;
        CMD_SATURATION: sat_nxt   = in_value;
        default:        ;
      endcase
    end
  end

  assign hue_entry = HUE_TAB[hue_nxt];

  always_comb begin
    push_valid       = take;
    push_item.on     = on_nxt;
    push_item.level  = level_nxt;
    push_item.sat    = sat_nxt;
    push_item.region = hue_entry[10:8];
    push_item.rem    = hue_entry[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      level_r <= LEVEL_RESET;
      hue_r   <= 8'd0;
      sat_r   <= 8'd0;
    end else begin
      on_r    <= on_nxt;
      level_r <= level_nxt;
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

### hw/rtl/hsvl_queue.sv
// Short snapshot queue between the front and the back end of the light
// controller. Depends on hsvl_pkg for the snapshot type.
module hsvl_queue #(
  parameter int unsigned Depth = hsvl_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  hsvl_pkg::hsvl_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output hsvl_pkg::hsvl_item_t pop_item
);
  import hsvl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  hsvl_item_t      slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/hsvl_back.sv
// Back end: turns one snapshot into an RGB color with a shared 8x8 multiplier
// sequenced over six steps, and holds it in the output register. Uses hsvl_pkg.
module hsvl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  hsvl_pkg::hsvl_item_t pop_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_lit
);
  import hsvl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] STEP_LAST = 3'd5;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  hsvl_item_t  item_r;
  logic [7:0]  mul_a, mul_b;
  logic [15:0] prod_r;
  logic [7:0]  quot;
  logic [7:0]  sr_r, st_r, p_r, q_r, t_r;
  logic [7:0]  red, green, blue;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;
  logic        out_lit_r;
  logic        load_out;

  assign pop_ready = (state_r == ST_IDLE);
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Multiplier operand schedule: s*rem, s*(255-rem), v*(255-s),
  // v*(255-s*rem/255), v*(255-s*(255-rem)/255). Each product is divided
  // by 255 in the cycle after it is registered.
  always_comb begin
    case (step_r)
      3'd0: begin
        mul_a = item_r.sat;
        mul_b = item_r.rem;
      end
      3'd1: begin
        mul_a = item_r.sat;
        mul_b = COMP_MAX - item_r.rem;
      end
      3'd2: begin
        mul_a = item_r.level;
        mul_b = COMP_MAX - item_r.sat;
      end
      3'd3: begin
        mul_a = item_r.level;
        mul_b = COMP_MAX - sr_r;
      end
      default: begin
        mul_a = item_r.level;
        mul_b = COMP_MAX - st_r;
      end
    endcase
  end

  assign quot = div255(prod_r);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          step_nxt = 3'd0;
          // Off and gray colors need no arithmetic.
          if (!pop_item.on || pop_item.sat == 8'd0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (!item_r.on) begin
      red   = 8'd0;
      green = 8'd0;
      blue  = 8'd0;
    end else if (item_r.sat == 8'd0) begin
      red   = item_r.level;
      green = item_r.level;
      blue  = item_r.level;
    end else begin
      case (item_r.region)
        3'd0: begin
          red = item_r.level; green = t_r;          blue = p_r;
        end
        3'd1: begin
          red = q_r;          green = item_r.level; blue = p_r;
        end
        3'd2: begin
          red = p_r;          green = item_r.level; blue = t_r;
        end
        3'd3: begin
          red = p_r;          green = q_r;          blue = item_r.level;
        end
        3'd4: begin
          red = t_r;          green = p_r;          blue = item_r.level;
        end
        default: begin
          red = item_r.level; green = p_r;          blue = q_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && pop_valid) begin
      item_r <= pop_item;
    end
    if (state_r == ST_CALC) begin
      prod_r <= mul_a * mul_b;
      case (step_r)
        3'd1:    sr_r <= quot;
        3'd2:    st_r <= quot;
        3'd3:    p_r  <= quot;
        3'd4:    q_r  <= quot;
        3'd5:    t_r  <= quot;
        default: ;
      endcase
    end
    if (load_out) begin
      out_red_r   <= red;
      out_green_r <= green;
      out_blue_r  <= blue;
      out_lit_r   <= item_r.on;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_lit   = out_lit_r;

endmodule

### tb/hsv_light_attribute_controller_core_tb.sv
// Self-checking testbench for hsv_light_attribute_controller_core.
// It predicts each strip color from the stored attributes and checks the results in order.
// Depends on hsvl_pkg for the command codes and on the core RTL.
module hsv_light_attribute_controller_core_tb;
  import hsvl_pkg::*;

  localparam logic [2:0] CMD_REFRESH   = 3'd4;
  localparam logic [2:0] CMD_TOP       = 3'd7;
  localparam int unsigned DEGREES      = 360;
  localparam int unsigned HUE_CODES    = 254;
  localparam int unsigned REGION_DEG   = 60;
  localparam int unsigned FULL_SCALE   = 255;
  localparam int RANDOM_WRITES         = 1700;
  localparam int SEGMENT_WRITES        = 100;
  localparam int LONG_HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES         = 20;
  localparam int CYCLE_LIMIT           = 1000000;
  localparam int REPORT_LIMIT          = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       lit;
  } color_t;

  // Tracks the light attributes and the colors still owed by the block.
  class strip_color_model;
    logic       on_state = 1'b0;
    logic [7:0] level = 8'd254;
    logic [7:0] hue = 8'd0;
    logic [7:0] sat = 8'd0;
    color_t     expected_colors[$];
    int         mismatches = 0;

    function color_t strip_color();
      color_t      c;
      int unsigned h, region, rem, v, s, p, q, t;
      c = '0;
      if (!on_state) return c;
      c.lit = 1'b1;
      v = level;
      s = sat;
      if (s == 0) begin
        c.red = 8'(v);
        c.green = 8'(v);
        c.blue = 8'(v);
        return c;
      end
      h = hue;
      h = (h * DEGREES) / HUE_CODES;
      // The top hue codes scale past a full turn and wrap back to red.
      if (h >= DEGREES) h = h - DEGREES;
      region = h / REGION_DEG;
      rem = ((h % REGION_DEG) * FULL_SCALE) / REGION_DEG;
      p = (v * (FULL_SCALE - s)) / FULL_SCALE;
      q = (v * (FULL_SCALE - (s * rem) / FULL_SCALE)) / FULL_SCALE;
      t = (v * (FULL_SCALE - (s * (FULL_SCALE - rem)) / FULL_SCALE)) / FULL_SCALE;
      case (region)
        0: begin c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p); end
        1: begin c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p); end
        2: begin c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t); end
        3: begin c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v); end
        4: begin c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v); end
        default: begin c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q); end
      endcase
      return c;
    endfunction

    function void note_write(logic [2:0] cmd, logic [7:0] val, logic ok);
      if (!ok) return;
      case (cmd)
        CMD_ON_OFF:     on_state = (val != 8'd0);
        CMD_LEVEL:      level = val;
        CMD_HUE:        hue = val;
        CMD_SATURATION: sat = val;
        default: ;
      endcase
      expected_colors.push_back(strip_color());
    endfunction

    function void check_color(color_t got);
      color_t want;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected color r=%0d g=%0d b=%0d lit=%0d", got.red, got.green,
                   got.blue, got.lit);
        return;
      end
      want = expected_colors.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.lit !== want.lit) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("color mismatch: expected r=%0d g=%0d b=%0d lit=%0d, %s",
                   want.red, want.green, want.blue, want.lit,
                   $sformatf("got r=%0d g=%0d b=%0d lit=%0d",
                             got.red, got.green, got.blue, got.lit));
      end
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_command = 3'd0;
  logic [7:0] in_value = 8'd0;
  logic       in_status_ok = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_lit;

  strip_color_model model;
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  hsv_light_attribute_controller_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_value     (in_value),
    .in_status_ok (in_status_ok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_lit      (out_lit)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hsv_light_attribute_controller_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      model.check_color({out_red, out_green, out_blue, out_lit});
  end

  // Mostly short idle periods with an occasional long one.
  function int pick_gap(int min_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return min_len;
    if (r < 92) return $urandom_range(min_len + 1, min_len + 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one write transaction and returns at the edge where it is accepted.
  task automatic send_write(logic [2:0] cmd, logic [7:0] val, logic ok);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_value <= val;
    in_status_ok <= ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model.note_write(cmd, val, ok);
  endtask

  task automatic idle_sender();
    int gap;
    gap = steady ? 0 : pick_gap(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_and_idle(logic [2:0] cmd, logic [7:0] val, logic ok);
    send_write(cmd, val, ok);
    idle_sender();
  endtask

  task automatic wait_for_colors();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int run_len;
    int stall_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 12);
        stall_len = pick_gap(1);
        out_ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin
    logic [2:0] cmd;
    logic [7:0] val;
    logic       ok;
    int         r;
    model = new;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: starts from the reset attributes with the light off.
    write_and_idle(CMD_REFRESH, 8'd0, 1'b1);
    write_and_idle(CMD_ON_OFF, 8'd1, 1'b0);
    write_and_idle(CMD_ON_OFF, 8'd1, 1'b1);
    write_and_idle(CMD_LEVEL, 8'd255, 1'b1);
    write_and_idle(CMD_SATURATION, 8'd255, 1'b1);
    write_and_idle(CMD_HUE, 8'd43, 1'b1);
    write_and_idle(CMD_HUE, 8'd85, 1'b1);
    write_and_idle(CMD_HUE, 8'd127, 1'b1);
    write_and_idle(CMD_HUE, 8'd170, 1'b1);
    write_and_idle(CMD_HUE, 8'd212, 1'b1);
    write_and_idle(CMD_HUE, 8'd254, 1'b1);
    write_and_idle(CMD_HUE, 8'd255, 1'b1);
    write_and_idle(CMD_SATURATION, 8'd1, 1'b1);
    write_and_idle(CMD_LEVEL, 8'd0, 1'b1);
    write_and_idle(CMD_LEVEL, 8'd128, 1'b1);
    for (int c = CMD_REFRESH + 1; c <= CMD_TOP; c++)
      write_and_idle(3'(c), 8'($urandom_range(0, 255)), 1'b1);
    write_and_idle(CMD_HUE, 8'd200, 1'b0);
    write_and_idle(CMD_SATURATION, 8'd0, 1'b1);
    write_and_idle(CMD_ON_OFF, 8'd0, 1'b1);
    write_and_idle(CMD_HUE, 8'd100, 1'b1);
    write_and_idle(CMD_ON_OFF, 8'd255, 1'b1);
    write_and_idle(CMD_SATURATION, 8'd128, 1'b1);
    wait_for_colors();

    // Random part, in segments that each either idle at random or run at full rate.
    for (int seg = 0; seg < RANDOM_WRITES / SEGMENT_WRITES; seg++) begin
      if (seg == 9) wait_for_colors();
      steady = ($urandom_range(0, 3) == 0);
      if (seg == 2) begin
        steady = 1'b0;
        hold_request = 1'b1;
      end
      for (int i = 0; i < SEGMENT_WRITES; i++) begin
        ok = ($urandom_range(0, 99) >= 8);
        val = pick_value();
        r = $urandom_range(0, 99);
        if (r < 8) begin
          cmd = CMD_ON_OFF;
          // Keep the light on most of the time so the color path is exercised.
          if ($urandom_range(0, 3) != 0 && val == 8'd0) val = 8'($urandom_range(1, 255));
        end else if (r < 30) begin
          cmd = CMD_LEVEL;
        end else if (r < 55) begin
          cmd = CMD_HUE;
        end else if (r < 80) begin
          cmd = CMD_SATURATION;
        end else begin
          cmd = 3'($urandom_range(CMD_REFRESH, CMD_TOP));
        end
        write_and_idle(cmd, val, ok);
      end
    end
    steady = 1'b0;

    wait_for_colors();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("hsv_light_attribute_controller_core test passed");
    end else begin
      $display("hsv_light_attribute_controller_core test failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/hsvl_pkg.sv
hw/rtl/hsvl_front.sv
hw/rtl/hsvl_queue.sv
hw/rtl/hsvl_back.sv
hw/rtl/hsv_light_attribute_controller_core.sv
tb/hsv_light_attribute_controller_core_tb.sv
